// ----- sv/assert_macros.svh -----
// Assertion macros for the port-level checker in sv/tpzs_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- sv/tpzs_pkg.sv -----
// Shared types, constants and helper functions of the torus point shader.
// No dependencies.
package tpzs_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 22;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELLS_W = $clog2(CELLS);
    localparam int CELL_W  = 11;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_TILT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_TILT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_SPIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_SPIN = 3'd3;

    localparam logic [7:0] GLYPH_SPACE = 8'd32;

    // 40 * 2^29, 12 * 2^29 and 2^29 - 1 for the projection
    localparam logic signed [43:0] X_OFF   = 44'sd21474836480;
    localparam logic signed [43:0] Y_OFF   = 44'sd6442450944;
    localparam logic signed [43:0] Q29_RND = 44'sd536870911;
    localparam logic signed [23:0] DEN_OFF = 24'sd81920;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_BIG,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_WB
    } t_back_state;

    typedef struct packed {
        logic              rd;
        logic              hit;
        logic [CELL_W-1:0] addr;
        logic [15:0]       dz;
        logic [7:0]        glyph;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Q1.14 product, truncated toward zero
    function automatic logic signed [25:0] m14(input logic signed [39:0] p);
        logic signed [39:0] adj;
        adj = p + (p[39] ? 40'sd16383 : 40'sd0);
        return adj[39:14];
    endfunction

    // coordinate = (off + prod) / 2^29, truncated toward zero
    function automatic logic signed [14:0] coord(input logic signed [43:0] n);
        logic signed [43:0] adj;
        adj = n + (n[43] ? Q29_RND : 44'sd0);
        return adj[43:29];
    endfunction

    function automatic logic [7:0] ramp_glyph(input logic [3:0] idx);
        logic [7:0] g;
        case (idx)
            4'd0:    g = ".";
            4'd1:    g = ",";
            4'd2:    g = "-";
            4'd3:    g = "~";
            4'd4:    g = ":";
            4'd5:    g = ";";
            4'd6:    g = "=";
            4'd7:    g = "!";
            4'd8:    g = "*";
            4'd9:    g = "#";
            4'd10:   g = "$";
            default: g = "@";
        endcase
        return g;
    endfunction

endpackage

// ----- sv/tpzs_queue.sv -----
// Two-entry command queue between the shader front and the store back end.
// Depends on tpzs_pkg.
module tpzs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tpzs_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output tpzs_pkg::t_cmd      o_head,
    output tpzs_pkg::t_q_status o_status
);

    tpzs_pkg::t_cmd r_mem [0:1];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_head         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

// ----- sv/tpzs_front.sv -----
// Front end: takes items; rotation, inverse depth and projection of plot items
// run on one shared multiplier and a bit-serial divider; queues a command.
// Depends on tpzs_pkg.
module tpzs_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpzs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                        i_cfg_data,
    input  logic                               i_enable,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic signed [15:0]                 i_sin_tube,
    input  logic signed [15:0]                 i_cos_tube,
    input  logic signed [15:0]                 i_sin_ring,
    input  logic signed [15:0]                 i_cos_ring,
    input  logic [tpzs_pkg::CELL_W-1:0]        i_read_cell,
    input  tpzs_pkg::t_q_status                i_q_status,
    output logic                               o_push,
    output tpzs_pkg::t_cmd                     o_cmd
);

    tpzs_pkg::t_front_state r_state, n_state;

    logic signed [15:0] r_sin_tilt, r_cos_tilt, r_sin_spin, r_cos_spin;
    logic               r_kind;
    logic signed [15:0] r_c, r_l, r_f, r_d;
    logic [tpzs_pkg::CELL_W-1:0] r_rcell;

    logic [4:0]         r_step;
    logic signed [39:0] r_prod;
    logic signed [23:0] r_ch, r_cd, r_lh, r_fe, r_fg, r_ld;
    logic signed [23:0] r_den, r_t, r_diff, r_lum, r_p, r_q;
    logic [19:0]        r_rem;
    logic [29:0]        r_quo;
    logic [4:0]         r_dcnt;
    logic [15:0]        r_dz;
    logic signed [14:0] r_x, r_y;

    logic signed [21:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [39:0] w_prod;
    logic signed [25:0] w_m;
    logic signed [23:0] w_v;
    logic signed [17:0] w_h;
    logic signed [43:0] w_pe;
    logic [20:0]        w_rem_sh;
    logic               w_ge;
    logic [29:0]        w_quo;
    logic               w_acc;
    logic               w_inside;
    logic [tpzs_pkg::CELL_W-1:0] w_cell;
    logic [3:0]         w_sh;

    function automatic logic signed [21:0] ext_a(input logic signed [15:0] v);
        return {{6{v[15]}}, v};
    endfunction

    function automatic logic signed [17:0] ext_b(input logic signed [15:0] v);
        return {{2{v[15]}}, v};
    endfunction

    assign w_h    = ext_b(r_d) + 18'sd32768;
    assign w_prod = mul_a * mul_b;
    assign w_m    = tpzs_pkg::m14(r_prod);
    assign w_v    = w_m[23:0];
    assign w_pe   = {{4{r_prod[39]}}, r_prod};
    assign w_acc  = i_valid && !o_stall;

    // restoring divide of 2^29: only the top dividend bit is set
    assign w_rem_sh = {r_rem, (r_dcnt == 5'd29)};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den[19:0]});
    assign w_quo    = {r_quo[28:0], w_ge};

    assign w_inside = (r_x > 15'sd0) && (r_x < 15'(tpzs_pkg::COLUMNS))
                   && (r_y > 15'sd0) && (r_y < 15'(tpzs_pkg::ROWS));
    assign w_cell   = tpzs_pkg::CELL_W'(32'(r_x) + tpzs_pkg::COLUMNS * 32'(r_y));

    always_comb begin
        if (r_lum <= 24'sd0)            w_sh = 4'd0;
        else if (r_lum[23:11] > 13'd11) w_sh = 4'd11;
        else                            w_sh = r_lum[14:11];
    end

    always_comb begin
        o_cmd = '0;
        if (r_kind) begin
            o_cmd.rd   = 1'b1;
            o_cmd.hit  = (32'(r_rcell) < tpzs_pkg::CELLS);
            o_cmd.addr = r_rcell;
        end else begin
            o_cmd.hit   = w_inside;
            o_cmd.addr  = w_inside ? w_cell : '0;
            o_cmd.dz    = r_dz;
            o_cmd.glyph = tpzs_pkg::ramp_glyph(w_sh);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpzs_pkg::F_IDLE: if (w_acc) n_state = i_kind ? tpzs_pkg::F_PUSH
                                                          : tpzs_pkg::F_MUL;
            tpzs_pkg::F_MUL:  if (r_step == 5'd16)
                                  n_state = (r_den > 24'sd0) ? tpzs_pkg::F_DIV
                                                             : tpzs_pkg::F_BIG;
            tpzs_pkg::F_DIV:  if (r_dcnt == 5'd0) n_state = tpzs_pkg::F_BIG;
            tpzs_pkg::F_BIG:  if (r_step == 5'd2) n_state = tpzs_pkg::F_PUSH;
            tpzs_pkg::F_PUSH: if (!i_q_status.full) n_state = tpzs_pkg::F_IDLE;
            default:          n_state = tpzs_pkg::F_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        o_stall = 1'b1;
        o_push  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            tpzs_pkg::F_IDLE: o_stall = !i_enable;
            tpzs_pkg::F_MUL: begin
                case (r_step)
                    5'd0:    begin mul_a = ext_a(r_c); mul_b = w_h;               end
                    5'd1:    begin mul_a = ext_a(r_c); mul_b = ext_b(r_d);        end
                    5'd2:    begin mul_a = ext_a(r_l); mul_b = w_h;               end
                    5'd3:    begin mul_a = ext_a(r_f); mul_b = ext_b(r_sin_tilt); end
                    5'd4:    begin mul_a = ext_a(r_f); mul_b = ext_b(r_cos_tilt); end
                    5'd5:    begin mul_a = ext_a(r_l); mul_b = ext_b(r_d);        end
                    5'd6:    begin mul_a = r_ch[21:0]; mul_b = ext_b(r_sin_tilt); end
                    5'd7:    begin mul_a = r_ch[21:0]; mul_b = ext_b(r_cos_tilt); end
                    5'd8:    begin mul_a = r_cd[21:0]; mul_b = ext_b(r_cos_tilt); end
                    5'd9:    begin mul_a = r_cd[21:0]; mul_b = ext_b(r_sin_tilt); end
                    5'd10:   begin mul_a = r_ld[21:0]; mul_b = ext_b(r_sin_spin); end
                    5'd11:   begin mul_a = r_lh[21:0]; mul_b = ext_b(r_cos_spin); end
                    5'd12:   begin mul_a = r_lh[21:0]; mul_b = ext_b(r_sin_spin); end
                    5'd13:   begin mul_a = r_t[21:0];  mul_b = ext_b(r_sin_spin); end
                    5'd14:   begin mul_a = r_t[21:0];  mul_b = ext_b(r_cos_spin); end
                    5'd15:   begin mul_a = r_diff[21:0]; mul_b = ext_b(r_cos_spin); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            tpzs_pkg::F_BIG: begin
                mul_b = {2'b00, r_dz};
                mul_a = (r_step == 5'd0) ? r_p[21:0] : r_q[21:0];
            end
            tpzs_pkg::F_PUSH: o_push = !i_q_status.full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tpzs_pkg::F_IDLE;
            r_sin_tilt <= 16'sd0;
            r_cos_tilt <= 16'sd16384;
            r_sin_spin <= 16'sd0;
            r_cos_spin <= 16'sd16384;
            r_step     <= 5'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpzs_pkg::CFG_SIN_TILT: r_sin_tilt <= i_cfg_data;
                    tpzs_pkg::CFG_COS_TILT: r_cos_tilt <= i_cfg_data;
                    tpzs_pkg::CFG_SIN_SPIN: r_sin_spin <= i_cfg_data;
                    tpzs_pkg::CFG_COS_SPIN: r_cos_spin <= i_cfg_data;
                    default: ;
                endcase
            end
            if (n_state != r_state) r_step <= 5'd0;
            else                    r_step <= r_step + 5'd1;
        end
    end

    // datapath: product of step s is folded in at step s + 1
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (r_state)
            tpzs_pkg::F_IDLE: begin
                if (w_acc) begin
                    r_kind  <= i_kind;
                    r_c     <= i_sin_tube;
                    r_l     <= i_cos_tube;
                    r_f     <= i_sin_ring;
                    r_d     <= i_cos_ring;
                    r_rcell <= i_read_cell;
                end
            end
            tpzs_pkg::F_MUL: begin
                case (r_step)
                    5'd1:  r_ch   <= w_v;
                    5'd2:  r_cd   <= w_v;
                    5'd3:  r_lh   <= w_v;
                    5'd4:  r_fe   <= w_v;
                    5'd5:  r_fg   <= w_v;
                    5'd6:  r_ld   <= w_v;
                    5'd7:  r_den  <= w_v + r_fg + tpzs_pkg::DEN_OFF;
                    5'd8:  r_t    <= w_v - r_fe;
                    5'd9:  r_diff <= r_fe - w_v;
                    5'd10: r_lum  <= -w_v - r_fg;
                    5'd11: r_lum  <= r_lum - w_v;
                    5'd12: r_p    <= w_v;
                    5'd13: r_q    <= w_v;
                    5'd14: r_p    <= r_p - w_v;
                    5'd15: r_q    <= r_q + w_v;
                    5'd16: begin
                        r_lum  <= r_lum + w_v;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_dcnt <= 5'd29;
                        r_dz   <= 16'd0;
                    end
                    default: ;
                endcase
            end
            tpzs_pkg::F_DIV: begin
                r_rem  <= w_ge ? 20'(w_rem_sh - {1'b0, r_den[19:0]}) : w_rem_sh[19:0];
                r_quo  <= w_quo;
                r_dcnt <= r_dcnt - 5'd1;
                // clamp the finished quotient to 16 bits
                if (r_dcnt == 5'd0)
                    r_dz <= (w_quo[29:16] != '0) ? 16'hFFFF : w_quo[15:0];
            end
            tpzs_pkg::F_BIG: begin
                if (r_step == 5'd1)
                    r_x <= tpzs_pkg::coord(tpzs_pkg::X_OFF + (w_pe <<< 5) - (w_pe <<< 1));
                if (r_step == 5'd2)
                    r_y <= tpzs_pkg::coord(tpzs_pkg::Y_OFF + (w_pe <<< 4) - w_pe);
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/tpzs_back.sv -----
// Back end: glyph and depth store, clearing pass, depth test and result beat.
// Depends on tpzs_pkg.
module tpzs_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tpzs_pkg::t_cmd               i_head,
    input  tpzs_pkg::t_q_status          i_q_status,
    output logic                         o_pop,
    output logic                         o_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_written,
    output logic [tpzs_pkg::CELL_W-1:0]  o_cell_res,
    output logic [7:0]                   o_glyph
);

    tpzs_pkg::t_back_state r_state, n_state;

    logic [23:0]                  r_mem [0:tpzs_pkg::CELLS-1];
    logic [23:0]                  r_rdata;
    logic [tpzs_pkg::CELLS_W-1:0] r_clr;
    tpzs_pkg::t_cmd               r_cmd;
    logic                         r_out_valid;
    logic                         r_written;
    logic [tpzs_pkg::CELL_W-1:0]  r_cell;
    logic [7:0]                   r_glyph;

    logic                         w_free;
    logic                         w_win;
    logic                         w_done;
    logic                         w_we;
    logic [tpzs_pkg::CELLS_W-1:0] w_waddr;
    logic [tpzs_pkg::CELLS_W-1:0] w_raddr;
    logic [23:0]                  w_wdata;
    logic [7:0]                   w_glyph;

    assign w_free  = !r_out_valid || !i_out_stall;
    assign w_win   = !r_cmd.rd && r_cmd.hit && (r_cmd.dz > r_rdata[15:0]);
    assign w_raddr = i_head.hit ? tpzs_pkg::CELLS_W'(i_head.addr) : '0;

    always_comb begin
        if (!r_cmd.hit) w_glyph = 8'd0;
        else if (w_win) w_glyph = r_cmd.glyph;
        else            w_glyph = r_rdata[23:16];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpzs_pkg::B_CLEAR: if (32'(r_clr) == tpzs_pkg::CELLS - 1) n_state = tpzs_pkg::B_IDLE;
            tpzs_pkg::B_IDLE:  if (!i_q_status.empty) n_state = tpzs_pkg::B_WB;
            tpzs_pkg::B_WB:    if (w_free) n_state = tpzs_pkg::B_IDLE;
            default:           n_state = tpzs_pkg::B_CLEAR;
        endcase
    end

    // outputs and store write
    always_comb begin
        o_pop   = 1'b0;
        o_ready = 1'b1;
        w_done  = 1'b0;
        w_we    = 1'b0;
        w_waddr = tpzs_pkg::CELLS_W'(r_cmd.addr);
        w_wdata = r_cmd.rd ? {tpzs_pkg::GLYPH_SPACE, 16'd0} : {r_cmd.glyph, r_cmd.dz};
        case (r_state)
            tpzs_pkg::B_CLEAR: begin
                o_ready = 1'b0;
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = {tpzs_pkg::GLYPH_SPACE, 16'd0};
            end
            tpzs_pkg::B_IDLE: o_pop = !i_q_status.empty;
            tpzs_pkg::B_WB: begin
                w_done = w_free;
                w_we   = w_free && r_cmd.hit && (r_cmd.rd || w_win);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (o_pop) begin
            r_rdata <= r_mem[w_raddr];
            r_cmd   <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpzs_pkg::B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tpzs_pkg::B_CLEAR) r_clr <= r_clr + 1'b1;
            if (w_done)            r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_written <= w_win;
            r_cell    <= r_cmd.addr;
            r_glyph   <= w_glyph;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_written   = r_written;
    assign o_cell_res  = r_cell;
    assign o_glyph     = r_glyph;

endmodule

// ----- sv/torus_point_zbuffer_shader_unit.sv -----
// Top level of the torus point z-buffer shader: front end, command queue, back end.
// Depends on tpzs_pkg, tpzs_front, tpzs_queue and tpzs_back.

// A plot item goes from acceptance to its queued command through 17 steps
// on the one shared 22x18 multiplier, the bit-serial inverse-depth divider
// (skipped when the denominator is not positive), 3 projection steps and
// one queue write; a read item goes straight to the queue write. The back
// end reads each command's cell, then writes back over the single store
// port, and waits while a result beat is stalled. One item is in the front
// end at a time; results come out in order, one per item. After reset the
// store is swept once, one cell a cycle, and no item is taken meanwhile;
// configuration writes are taken throughout.
module torus_point_zbuffer_shader_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpzs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic signed [15:0]                 i_sin_tube,
    input  logic signed [15:0]                 i_cos_tube,
    input  logic signed [15:0]                 i_sin_ring,
    input  logic signed [15:0]                 i_cos_ring,
    input  logic [tpzs_pkg::CELL_W-1:0]        i_read_cell,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_written,
    output logic [tpzs_pkg::CELL_W-1:0]        o_cell_res,
    output logic [7:0]                         o_glyph
);

    tpzs_pkg::t_cmd      w_push_cmd;
    tpzs_pkg::t_cmd      w_head;
    tpzs_pkg::t_q_status w_q_status;
    logic                w_push;
    logic                w_pop;
    logic                w_ready;

    tpzs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_enable    (w_ready),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_kind      (i_kind),
        .i_sin_tube  (i_sin_tube),
        .i_cos_tube  (i_cos_tube),
        .i_sin_ring  (i_sin_ring),
        .i_cos_ring  (i_cos_ring),
        .i_read_cell (i_read_cell),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    tpzs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    tpzs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_ready     (w_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_written   (o_written),
        .o_cell_res  (o_cell_res),
        .o_glyph     (o_glyph)
    );

endmodule

// ----- sv/tpzs_checker.sv -----
// Port-level checks of the torus point shader, bound to the top level.
// Depends on tpzs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpzs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_we,
    input logic [tpzs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input logic [15:0]                        i_cfg_data,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_kind,
    input logic signed [15:0]                 i_sin_tube,
    input logic signed [15:0]                 i_cos_tube,
    input logic signed [15:0]                 i_sin_ring,
    input logic signed [15:0]                 i_cos_ring,
    input logic [tpzs_pkg::CELL_W-1:0]        i_read_cell,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_written,
    input logic [tpzs_pkg::CELL_W-1:0]        o_cell_res,
    input logic [7:0]                         o_glyph
);

    // hold a stalled result beat
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_res) && $stable(o_glyph) && $stable(o_written))

    // a winning point lands inside the store with a ramp glyph
    `ASSERT_RST(a_win_cell, i_clk, i_rst_n, o_out_valid && o_written |-> 32'(o_cell_res) < tpzs_pkg::CELLS)
    `ASSERT_RST(a_win_glyph, i_clk, i_rst_n, o_out_valid && o_written |-> o_glyph != tpzs_pkg::GLYPH_SPACE && o_glyph != 8'd0)

    // the clearing pass blocks input straight after reset
    `ASSERT_ALL(a_clear_stall, i_clk, !i_rst_n |=> o_in_stall)

endmodule

bind torus_point_zbuffer_shader_unit tpzs_checker u_tpzs_checker (.*);

// ----- verif/tpzs_checker.sv -----
// Checker for the torus point z-buffer shader: watches the config port and both channels,
// predicts each result from its own copy of the stores and compares. Depends on tpzs_pkg.
`timescale 1ns / 100ps

module tpzs_tb_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpzs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                        i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_kind,
    input  logic signed [15:0]                 i_sin_tube,
    input  logic signed [15:0]                 i_cos_tube,
    input  logic signed [15:0]                 i_sin_ring,
    input  logic signed [15:0]                 i_cos_ring,
    input  logic [tpzs_pkg::CELL_W-1:0]        i_read_cell,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_written,
    input  logic [tpzs_pkg::CELL_W-1:0]        i_cell_res,
    input  logic [7:0]                         i_glyph,
    output int                                 o_fails,
    output int                                 o_pending
);

    localparam longint Q29 = 64'sd536870912;
    localparam string SHADES = ".,-~:;=!*#$@";

    typedef struct {
        logic                        written;
        logic [tpzs_pkg::CELL_W-1:0] loc;
        logic [7:0]                  glyph;
    } t_cell_beat;

    longint            sin_tilt, cos_tilt, sin_spin, cos_spin;
    logic [7:0]        glyph_mem [tpzs_pkg::CELLS];
    logic [15:0]       depth_mem [tpzs_pkg::CELLS];
    t_cell_beat        awaited [$];

    function automatic longint q14(input longint a, input longint b);
        return (a * b) / 16384;
    endfunction

    // Rotate, project and depth-test one point, updating the stores
    function automatic t_cell_beat shade_point(input longint c, input longint l,
                                               input longint f, input longint d);
        t_cell_beat r;
        longint h, ch, den, dz, t, lh, p, q, x, y, cd, lum, sh, o;
        r = '{written: 1'b0, loc: '0, glyph: 8'd0};
        h   = d + 32768;
        ch  = q14(c, h);
        den = q14(ch, sin_tilt) + q14(f, cos_tilt) + 81920;
        dz  = 0;
        if (den > 0) begin
            dz = Q29 / den;
            if (dz > 65535) dz = 65535;
        end
        t  = q14(ch, cos_tilt) - q14(f, sin_tilt);
        lh = q14(l, h);
        p  = q14(lh, cos_spin) - q14(t, sin_spin);
        q  = q14(lh, sin_spin) + q14(t, cos_spin);
        x  = (40 * Q29 + 30 * dz * p) / Q29;
        y  = (12 * Q29 + 15 * dz * q) / Q29;
        cd  = q14(c, d);
        lum = q14(q14(f, sin_tilt) - q14(cd, cos_tilt), cos_spin) - q14(cd, sin_tilt)
            - q14(f, cos_tilt) - q14(q14(l, d), sin_spin);
        sh = (8 * lum) / 16384;
        if (sh < 0) sh = 0;
        if (sh > 11) sh = 11;
        if (x > 0 && x < tpzs_pkg::COLUMNS && y > 0 && y < tpzs_pkg::ROWS) begin
            o = x + tpzs_pkg::COLUMNS * y;
            r.loc = o[tpzs_pkg::CELL_W-1:0];
            if (dz > longint'(depth_mem[o])) begin
                depth_mem[o] = dz[15:0];
                glyph_mem[o] = SHADES[sh];
                r.written = 1'b1;
            end
            r.glyph = glyph_mem[o];
        end
        return r;
    endfunction

    function automatic t_cell_beat read_clear(input logic [tpzs_pkg::CELL_W-1:0] idx);
        t_cell_beat r;
        r = '{written: 1'b0, loc: idx, glyph: 8'd0};
        if (idx < tpzs_pkg::CELLS) begin
            r.glyph = glyph_mem[idx];
            glyph_mem[idx] = tpzs_pkg::GLYPH_SPACE;
            depth_mem[idx] = 16'd0;
        end
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fails++;
    endtask

    initial o_fails = 0;

    always @(posedge i_clk) begin
        t_cell_beat want;
        if (!i_rst_n) begin
            sin_tilt = 0;
            cos_tilt = 16384;
            sin_spin = 0;
            cos_spin = 16384;
            for (int i = 0; i < tpzs_pkg::CELLS; i++) begin
                glyph_mem[i] = tpzs_pkg::GLYPH_SPACE;
                depth_mem[i] = 16'd0;
            end
            awaited.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpzs_pkg::CFG_SIN_TILT: sin_tilt = longint'($signed(i_cfg_data));
                    tpzs_pkg::CFG_COS_TILT: cos_tilt = longint'($signed(i_cfg_data));
                    tpzs_pkg::CFG_SIN_SPIN: sin_spin = longint'($signed(i_cfg_data));
                    tpzs_pkg::CFG_COS_SPIN: cos_spin = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            // retire the outgoing beat before queueing the new one
            if (i_out_valid && !i_out_stall) begin
                if (awaited.size() == 0) begin
                    report("unexpected result beat", 1, 0);
                end else begin
                    want = awaited.pop_front();
                    if (i_written !== want.written) report("written", i_written, want.written);
                    if (i_cell_res !== want.loc) report("cell", i_cell_res, want.loc);
                    if (i_glyph !== want.glyph) report("glyph", i_glyph, want.glyph);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind) awaited.push_back(read_clear(i_read_cell));
                else awaited.push_back(shade_point(i_sin_tube, i_cos_tube,
                                                   i_sin_ring, i_cos_ring));
            end
        end
        o_pending = awaited.size();
    end

endmodule

// ----- verif/torus_point_zbuffer_shader_unit_tb.sv -----
// Testbench top for torus_point_zbuffer_shader_unit: clock, reset, configuration phases,
// directed and random stimulus, verdict. Depends on tpzs_pkg and tpzs_tb_checker.
`timescale 1ns / 100ps

module torus_point_zbuffer_shader_unit_tb;

    localparam logic [tpzs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic KIND_PLOT = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam logic signed [15:0] ONE = 16'sd16384;

    logic               i_clk, i_rst_n;
    logic               i_cfg_we;
    logic [tpzs_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid, o_in_stall, i_kind;
    logic signed [15:0] i_sin_tube, i_cos_tube, i_sin_ring, i_cos_ring;
    logic [tpzs_pkg::CELL_W-1:0] i_read_cell;
    logic               o_out_valid, i_out_stall, o_written;
    logic [tpzs_pkg::CELL_W-1:0] o_cell_res;
    logic [7:0]         o_glyph;
    int                 fails, pending;
    bit                 quiet;

    torus_point_zbuffer_shader_unit u_top (.*);

    tpzs_tb_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_kind,
        .i_sin_tube, .i_cos_tube, .i_sin_ring, .i_cos_ring, .i_read_cell,
        .i_out_valid(o_out_valid), .i_out_stall, .i_written(o_written),
        .i_cell_res(o_cell_res), .i_glyph(o_glyph),
        .o_fails(fails), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    // receiver back-pressure in bursts
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                i_out_stall = 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end
        end
    end

    function automatic logic signed [15:0] to_q14(input real v);
        return 16'($rtoi(v * ONE));
    endfunction

    // call at a falling edge; returns at a falling edge after acceptance, at times after a random idle gap
    task automatic send_beat(input logic kind, input logic signed [15:0] c, l, f, d,
                             input logic [tpzs_pkg::CELL_W-1:0] rcell);
        i_in_valid  = 1'b1;
        i_kind      = kind;
        i_sin_tube  = c;
        i_cos_tube  = l;
        i_sin_ring  = f;
        i_cos_ring  = d;
        i_read_cell = rcell;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    task automatic plot_torus();
        real a, b;
        a = $urandom_range(0, 6283) / 1000.0;
        b = $urandom_range(0, 6283) / 1000.0;
        send_beat(KIND_PLOT, to_q14($sin(a)), to_q14($cos(a)), to_q14($sin(b)),
                  to_q14($cos(b)), 11'($urandom));
    endtask

    task automatic set_reg(input logic [tpzs_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // hold until drained, then retune both rotations
    task automatic retune(input logic signed [15:0] st, ct, ss, cs);
        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (60) @(negedge i_clk);
        set_reg(tpzs_pkg::CFG_SIN_TILT, st);
        set_reg(tpzs_pkg::CFG_COS_TILT, ct);
        set_reg(tpzs_pkg::CFG_SIN_SPIN, ss);
        set_reg(tpzs_pkg::CFG_COS_SPIN, cs);
        set_reg(CFG_SPARE, 16'hFFFF);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1: send_beat(KIND_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), $urandom_range(0, 1) ? 11'($urandom)
                                : 11'(tpzs_pkg::COLUMNS * $urandom_range(1, 21)
                                      + $urandom_range(1, 79)));
                2:    send_beat(KIND_PLOT, 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 11'($urandom));
                default: plot_torus();
            endcase
        end
    endtask

    initial begin
        real a, b;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = tpzs_pkg::CFG_SIN_TILT;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_PLOT;
        i_sin_tube  = '0;
        i_cos_tube  = '0;
        i_sin_ring  = '0;
        i_cos_ring  = '0;
        i_read_cell = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity rotation, extremes, depth losers, reads in and out of range
        send_beat(KIND_PLOT, 0, 0, 0, 0, 0);
        send_beat(KIND_PLOT, 0, ONE, 0, ONE, 0);
        send_beat(KIND_PLOT, 0, ONE, 0, ONE, 0);
        send_beat(KIND_PLOT, ONE, 0, -ONE, 0, 0);
        send_beat(KIND_PLOT, -ONE, -ONE, ONE, -ONE, 0);
        send_beat(KIND_PLOT, -ONE, ONE, -ONE, ONE, 0);
        send_beat(KIND_PLOT, ONE, ONE, ONE, ONE, 0);
        send_beat(KIND_PLOT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 11'h7FF);
        send_beat(KIND_PLOT, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0);
        send_beat(KIND_READ, 0, 0, 0, 0, 11'(40 + tpzs_pkg::COLUMNS * 12));
        send_beat(KIND_READ, 0, 0, 0, 0, 11'(40 + tpzs_pkg::COLUMNS * 12));
        send_beat(KIND_READ, 0, 0, 0, 0, 11'(tpzs_pkg::CELLS));
        send_beat(KIND_READ, 0, 0, 0, 0, 11'h7FF);
        send_beat(KIND_READ, 0, 0, 0, 0, 0);
        send_beat(KIND_READ, 0, 0, 0, 0, 11'(tpzs_pkg::CELLS - 1));
        random_phase(250);

        // quarter tilt: a large negative tube sine drives the denominator below zero
        retune(ONE, 0, 0, ONE);
        send_beat(KIND_PLOT, -16'sh8000, 0, -16'sh8000, 16'sh7FFF, 0);
        send_beat(KIND_PLOT, -ONE, 0, -ONE, ONE, 0);
        random_phase(280);

        retune(-ONE, 0, -ONE, 0);
        random_phase(280);

        retune(-ONE, -ONE, ONE, -ONE);
        random_phase(280);

        a = $urandom_range(0, 6283) / 1000.0;
        b = $urandom_range(0, 6283) / 1000.0;
        retune(to_q14($sin(a)), to_q14($cos(a)), to_q14($sin(b)), to_q14($cos(b)));
        random_phase(280);

        a = $urandom_range(0, 6283) / 1000.0;
        b = $urandom_range(0, 6283) / 1000.0;
        retune(to_q14($sin(a)), to_q14($cos(a)), to_q14($sin(b)), to_q14($cos(b)));
        quiet = 1'b1;
        random_phase(300);

        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
